### sv/vva_pkg.sv
// ----------------------------------------------------------------------------
// vva_pkg: shared types and helpers for the vector ALU
// Q format constants, opcode codes, pipeline payload and saturation helpers.
// ----------------------------------------------------------------------------
package vva_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;              // data word width
  localparam int PW        = 2 * DW;          // product width
  localparam int SW        = PW + 2;          // sum of three products
  localparam int MAG_W     = DW + FRAC_BITS;  // scaled dividend magnitude
  localparam int NUM_W     = MAG_W + 1;       // 2*m + den
  localparam int DEN_W     = DW + 1;          // divisor / rounded root
  localparam int DIV_W     = DEN_W + 1;       // 2*den
  localparam int QB        = DW;              // quotient bits resolved
  localparam int SQ_STEPS  = DW;              // root bits resolved

  localparam logic [DW-1:0] WMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] WMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [SW-1:0] SMAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
  localparam logic signed [SW-1:0] HALF = {{(SW-1){1'b0}}, 1'b1} << (FRAC_BITS-1);

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_SCALE = 3'd2,
    CMD_DIV   = 3'd3,
    CMD_DOT   = 3'd4,
    CMD_CROSS = 3'd5,
    CMD_NORM  = 3'd6,
    CMD_NRMZ  = 3'd7
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [2:0][DW-1:0] a;
    logic [DW-1:0]      s;
    logic [2:0][DW-1:0] r;
    logic [DW-1:0]      sc;
    logic               sat;
    logic               dz;
    logic [2:0]         neg;
  } pay_t;

  typedef struct packed {
    logic [DW-1:0] val;
    logic          sat;
  } sval_t;

  function automatic sval_t sat_clamp(input logic signed [SW-1:0] y);
    sval_t res;
    res.sat = 1'b1;
    if (y > SMAX) begin
      res.val = WMAX;
    end else if (y < SMIN) begin
      res.val = WMIN;
    end else begin
      res.val = y[DW-1:0];
      res.sat = 1'b0;
    end
    return res;
  endfunction

  function automatic sval_t round_clamp(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] y;
    y = (x + HALF) >>> FRAC_BITS;
    return sat_clamp(y);
  endfunction

endpackage

### sv/vva_sqrt.sv
// ----------------------------------------------------------------------------
// vva_sqrt: pipelined integer square root
// One root bit per stage, then a round-to-nearest stage.
// ----------------------------------------------------------------------------
module vva_sqrt import vva_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [PW-1:0]    in_n,
  input  pay_t             in_pay,
  output logic             out_valid,
  output logic [DEN_W-1:0] out_root,
  output pay_t             out_pay
);

  logic [SQ_STEPS-1:0] v_r, v_nxt;
  logic [PW-1:0]       n_r   [SQ_STEPS];
  logic [PW-1:0]       n_nxt [SQ_STEPS];
  logic [DW-1:0]       rt_r  [SQ_STEPS];
  logic [DW-1:0]       rt_nxt[SQ_STEPS];
  logic [DW:0]         rm_r  [SQ_STEPS];
  logic [DW:0]         rm_nxt[SQ_STEPS];
  pay_t                p_r   [SQ_STEPS];
  pay_t                p_nxt [SQ_STEPS];

  logic             ov_r;
  logic [DEN_W-1:0] root_r;
  pay_t             opay_r;

  always_comb begin
    logic          vi;
    logic [PW-1:0] ni;
    logic [DW-1:0] ri;
    logic [DW:0]   mi;
    pay_t          pi;
    logic [DW+2:0] acc;
    logic [DW+2:0] trial;
    logic          fit;
    for (int k = 0; k < SQ_STEPS; k++) begin
      if (k == 0) begin
        vi = in_valid;
        ni = in_n;
        ri = '0;
        mi = '0;
        pi = in_pay;
      end else begin
        vi = v_r[k-1];
        ni = n_r[k-1];
        ri = rt_r[k-1];
        mi = rm_r[k-1];
        pi = p_r[k-1];
      end
      acc       = {mi, ni[PW-1 -: 2]};
      trial     = {1'b0, ri, 2'b01};
      fit       = (acc >= trial);
      v_nxt[k]  = vi;
      n_nxt[k]  = {ni[PW-3:0], 2'b00};
      rt_nxt[k] = {ri[DW-2:0], fit};
      rm_nxt[k] = fit ? (DW+1)'(acc - trial) : acc[DW:0];
      p_nxt[k]  = pi;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      ov_r <= 1'b0;
    end else if (en) begin
      v_r  <= v_nxt;
      ov_r <= v_r[SQ_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r    <= n_nxt;
      rt_r   <= rt_nxt;
      rm_r   <= rm_nxt;
      p_r    <= p_nxt;
      root_r <= {1'b0, rt_r[SQ_STEPS-1]} +
                DEN_W'(rm_r[SQ_STEPS-1] > {1'b0, rt_r[SQ_STEPS-1]});
      opay_r <= p_r[SQ_STEPS-1];
    end
  end

  assign out_valid = ov_r;
  assign out_root  = root_r;
  assign out_pay   = opay_r;

endmodule

### sv/vva_div.sv
// ----------------------------------------------------------------------------
// vva_div: pipelined three-lane rounding divider
// Quotient (2m+d)/(2d), one bit per stage, with sign and saturation.
// ----------------------------------------------------------------------------
module vva_div import vva_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2:0][MAG_W-1:0] in_mag,
  input  logic [DEN_W-1:0]      in_den,
  input  pay_t                  in_pay,
  output logic                  out_valid,
  output logic [2:0][DW-1:0]    out_q,
  output logic                  out_sat,
  output pay_t                  out_pay
);

  logic             v0_r;
  logic [NUM_W-1:0] n0_r [3];
  logic [DIV_W-1:0] d0_r;
  pay_t             p0_r;

  logic [QB-1:0]    v_r, v_nxt;
  logic [QB-1:0]    nl_r  [QB][3];
  logic [QB-1:0]    nl_nxt[QB][3];
  logic [DIV_W-1:0] rm_r  [QB][3];
  logic [DIV_W-1:0] rm_nxt[QB][3];
  logic [QB-1:0]    q_r   [QB][3];
  logic [QB-1:0]    q_nxt [QB][3];
  logic [2:0]       ov_r  [QB];
  logic [2:0]       ov_nxt[QB];
  logic [DIV_W-1:0] d_r   [QB];
  logic [DIV_W-1:0] d_nxt [QB];
  pay_t             p_r   [QB];
  pay_t             p_nxt [QB];

  logic               fv_r;
  logic [2:0][DW-1:0] fq_r, fq_nxt;
  logic               fsat_r, fsat_nxt;
  pay_t               fpay_r;

  always_comb begin
    logic [QB-1:0]    nlo;
    logic [DIV_W-1:0] rem;
    logic [QB-1:0]    qi;
    logic             ovi;
    logic [DIV_W:0]   acc;
    logic             fit;
    for (int j = 0; j < QB; j++) begin
      v_nxt[j] = (j == 0) ? v0_r : v_r[j-1];
      d_nxt[j] = (j == 0) ? d0_r : d_r[j-1];
      p_nxt[j] = (j == 0) ? p0_r : p_r[j-1];
      for (int i = 0; i < 3; i++) begin
        if (j == 0) begin
          nlo = n0_r[i][QB-1:0];
          rem = DIV_W'(n0_r[i][NUM_W-1:QB]);
          ovi = (DIV_W'(n0_r[i][NUM_W-1:QB]) >= d0_r);
          qi  = '0;
        end else begin
          nlo = nl_r[j-1][i];
          rem = rm_r[j-1][i];
          ovi = ov_r[j-1][i];
          qi  = q_r[j-1][i];
        end
        acc = {rem, nlo[QB-1]};
        fit = (acc >= {1'b0, d_nxt[j]});
        rm_nxt[j][i] = fit ? DIV_W'(acc - {1'b0, d_nxt[j]}) : acc[DIV_W-1:0];
        nl_nxt[j][i] = {nlo[QB-2:0], 1'b0};
        q_nxt[j][i]  = {qi[QB-2:0], fit};
        ov_nxt[j][i] = ovi;
      end
    end
  end

  always_comb begin
    logic          neg;
    logic          over;
    logic [DW-1:0] q;
    fsat_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      neg  = p_r[QB-1].neg[i];
      q    = q_r[QB-1][i];
      over = ov_r[QB-1][i] | (neg ? (q[DW-1] & (|q[DW-2:0])) : q[DW-1]);
      if (over) begin
        fq_nxt[i] = neg ? WMIN : WMAX;
      end else begin
        fq_nxt[i] = neg ? (~q + DW'(1)) : q;
      end
      fsat_nxt = fsat_nxt | over;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v_r  <= '0;
      fv_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v_r  <= v_nxt;
      fv_r <= v_r[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n0_r[i] <= {in_mag[i], 1'b0} + NUM_W'(in_den);
      end
      d0_r   <= {in_den, 1'b0};
      p0_r   <= in_pay;
      nl_r   <= nl_nxt;
      rm_r   <= rm_nxt;
      q_r    <= q_nxt;
      ov_r   <= ov_nxt;
      d_r    <= d_nxt;
      p_r    <= p_nxt;
      fq_r   <= fq_nxt;
      fsat_r <= fsat_nxt;
      fpay_r <= p_r[QB-1];
    end
  end

  assign out_valid = fv_r;
  assign out_q     = fq_r;
  assign out_sat   = fsat_r;
  assign out_pay   = fpay_r;

endmodule

### sv/vec3_vector_alu.sv
// ----------------------------------------------------------------------------
// vec3_vector_alu: three-component Q16.16 vector unit
// Add, sub, scale, divide, dot, cross, norm and normalize with saturation.
// ----------------------------------------------------------------------------
// Requests enter on the in_ stream: in_tuser carries the opcode, in_tdata the
// vectors A, B and the scalar. Results leave on the out_ stream: out_tdata
// carries rx, ry, rz and scalar_out, out_tuser the saturated and div_zero
// flags. One result per request, in order.
// Every opcode runs the full pipe: 3 multiply/sum/round stages, 33
// square-root stages (one root bit each plus rounding), one divisor setup
// stage and 34 divider stages (operand setup, one quotient bit each,
// sign/clamp), and the output register. Throughput is one request per cycle
// while the skid register is empty.
// Reset clears all valid bits; the pipe comes up empty with in_tready high.
// When the receiver stalls, a one-entry skid register takes the waiting
// result and the whole pipe holds until it drains; nothing is dropped.
// ----------------------------------------------------------------------------
module vec3_vector_alu import vva_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [223:0]   in_tdata,   // ax, ay, az, bx, by, bz, scalar_in
  input  logic [2:0]     in_tuser,   // cmd
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [127:0]   out_tdata,  // rx, ry, rz, scalar_out
  output logic [1:0]     out_tuser   // saturated, div_zero
);

  logic en;

  // stage 1: products
  logic                 v1_r;
  pay_t                 pay1_r, pay1_nxt;
  logic [2:0][DW-1:0]   b1_r;
  logic signed [PW-1:0] p1_r  [6];
  logic signed [PW-1:0] p1_nxt[6];

  // stage 2: sums
  logic                 v2_r;
  pay_t                 pay2_r;
  logic signed [SW-1:0] t2_r  [3];
  logic signed [SW-1:0] t2_nxt[3];
  logic signed [SW-1:0] sum2_r, sum2_nxt;
  logic signed [DW:0]   as2_r [3];
  logic signed [DW:0]   as2_nxt[3];

  // stage 3: round and clamp
  logic          v3_r;
  pay_t          pay3_r, pay3_nxt;
  logic [PW-1:0] sq3_r;

  // root
  logic             sq_v;
  logic [DEN_W-1:0] sq_root;
  pay_t             sq_pay;

  // divisor setup
  logic                  pv_r;
  logic [2:0][MAG_W-1:0] pmag_r, pmag_nxt;
  logic [DEN_W-1:0]      pden_r, pden_nxt;
  pay_t                  ppay_r, ppay_nxt;

  // divider
  logic               dv_v;
  logic [2:0][DW-1:0] dv_q;
  logic               dv_sat;
  pay_t               dv_pay;

  // output and skid
  logic         ov_r;
  logic [127:0] od_r, od_nxt;
  logic [1:0]   ou_r, ou_nxt;
  logic         hold_v_r;
  logic [127:0] hold_d_r;
  logic [1:0]   hold_u_r;

  assign en        = !hold_v_r;
  assign in_tready = en;

  always_comb begin
    logic signed [DW-1:0] a  [3];
    logic signed [DW-1:0] b  [3];
    logic signed [DW-1:0] s;
    logic signed [DW-1:0] ma [6];
    logic signed [DW-1:0] mb [6];
    cmd_t                 cmd;
    cmd = cmd_t'(in_tuser);
    s   = in_tdata[6*DW +: DW];
    for (int i = 0; i < 3; i++) begin
      a[i] = in_tdata[i*DW +: DW];
      b[i] = in_tdata[(3+i)*DW +: DW];
    end
    for (int i = 0; i < 3; i++) begin
      ma[i]   = (cmd == CMD_CROSS) ? a[(i+1)%3] : a[i];
      ma[i+3] = a[(i+2)%3];
      mb[i+3] = (cmd == CMD_CROSS) ? b[(i+1)%3] : '0;
      unique case (cmd)
        CMD_SCALE:          mb[i] = s;
        CMD_DOT:            mb[i] = b[i];
        CMD_CROSS:          mb[i] = b[(i+2)%3];
        CMD_NORM, CMD_NRMZ: mb[i] = a[i];
        default:            mb[i] = '0;
      endcase
    end
    for (int k = 0; k < 6; k++) begin
      p1_nxt[k] = PW'(ma[k]) * PW'(mb[k]);
    end
    pay1_nxt     = '0;
    pay1_nxt.cmd = cmd;
    pay1_nxt.s   = s;
    for (int i = 0; i < 3; i++) begin
      pay1_nxt.a[i] = a[i];
    end
  end

  always_comb begin
    sum2_nxt = SW'(p1_r[0]) + SW'(p1_r[1]) + SW'(p1_r[2]);
    for (int i = 0; i < 3; i++) begin
      t2_nxt[i] = SW'(p1_r[i]) - SW'(p1_r[i+3]);
      if (pay1_r.cmd == CMD_SUB) begin
        as2_nxt[i] = $signed({pay1_r.a[i][DW-1], pay1_r.a[i]}) -
                     $signed({b1_r[i][DW-1], b1_r[i]});
      end else begin
        as2_nxt[i] = $signed({pay1_r.a[i][DW-1], pay1_r.a[i]}) +
                     $signed({b1_r[i][DW-1], b1_r[i]});
      end
    end
  end

  always_comb begin
    sval_t sv [3];
    sval_t ss;
    pay3_nxt = pay2_r;
    ss = round_clamp(sum2_r);
    for (int i = 0; i < 3; i++) begin
      sv[i] = '0;
    end
    unique case (pay2_r.cmd)
      CMD_ADD, CMD_SUB: begin
        for (int i = 0; i < 3; i++) begin
          sv[i] = sat_clamp(SW'(as2_r[i]));
        end
      end
      CMD_SCALE, CMD_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          sv[i] = round_clamp(t2_r[i]);
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      pay3_nxt.r[i] = sv[i].val;
    end
    pay3_nxt.sat = sv[0].sat | sv[1].sat | sv[2].sat;
    if (pay2_r.cmd == CMD_DOT) begin
      pay3_nxt.sc  = ss.val;
      pay3_nxt.sat = ss.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay1_r <= pay1_nxt;
      for (int i = 0; i < 3; i++) begin
        b1_r[i] <= in_tdata[(3+i)*DW +: DW];
      end
      p1_r   <= p1_nxt;
      pay2_r <= pay1_r;
      t2_r   <= t2_nxt;
      sum2_r <= sum2_nxt;
      as2_r  <= as2_nxt;
      pay3_r <= pay3_nxt;
      sq3_r  <= sum2_r[PW-1:0];
    end
  end

  vva_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_n      (sq3_r),
    .in_pay    (pay3_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_pay   (sq_pay)
  );

  always_comb begin
    logic [DW-1:0] sabs;
    logic [DW-1:0] aabs;
    sval_t         nc;
    ppay_nxt = sq_pay;
    sabs     = sq_pay.s[DW-1] ? (~sq_pay.s + DW'(1)) : sq_pay.s;
    nc       = sat_clamp(SW'(sq_root));
    pden_nxt = DEN_W'(1);
    for (int i = 0; i < 3; i++) begin
      aabs        = sq_pay.a[i][DW-1] ? (~sq_pay.a[i] + DW'(1)) : sq_pay.a[i];
      pmag_nxt[i] = {aabs, {FRAC_BITS{1'b0}}};
    end
    unique case (sq_pay.cmd)
      CMD_DIV: begin
        pden_nxt    = {1'b0, sabs};
        ppay_nxt.dz = (sq_pay.s == '0);
        for (int i = 0; i < 3; i++) begin
          ppay_nxt.neg[i] = sq_pay.a[i][DW-1] ^ sq_pay.s[DW-1];
        end
      end
      CMD_NRMZ: begin
        pden_nxt    = sq_root;
        ppay_nxt.dz = (sq_root == '0);
        for (int i = 0; i < 3; i++) begin
          ppay_nxt.neg[i] = sq_pay.a[i][DW-1];
        end
      end
      CMD_NORM: begin
        ppay_nxt.sc  = nc.val;
        ppay_nxt.sat = nc.sat;
      end
      default: begin
      end
    endcase
    if (ppay_nxt.dz) begin
      pden_nxt = DEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (en) begin
      pv_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pmag_r <= pmag_nxt;
      pden_r <= pden_nxt;
      ppay_r <= ppay_nxt;
    end
  end

  vva_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pv_r),
    .in_mag    (pmag_r),
    .in_den    (pden_r),
    .in_pay    (ppay_r),
    .out_valid (dv_v),
    .out_q     (dv_q),
    .out_sat   (dv_sat),
    .out_pay   (dv_pay)
  );

  always_comb begin
    if (dv_pay.dz) begin
      od_nxt = '0;
      ou_nxt = 2'b10;
    end else if (dv_pay.cmd == CMD_DIV || dv_pay.cmd == CMD_NRMZ) begin
      od_nxt = {{DW{1'b0}}, dv_q[2], dv_q[1], dv_q[0]};
      ou_nxt = {1'b0, dv_sat};
    end else begin
      od_nxt = {dv_pay.sc, dv_pay.r[2], dv_pay.r[1], dv_pay.r[0]};
      ou_nxt = {1'b0, dv_pay.sat};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r     <= 1'b0;
      hold_v_r <= 1'b0;
    end else begin
      if (en) begin
        ov_r <= dv_v;
      end
      if (hold_v_r) begin
        if (out_tready) begin
          hold_v_r <= 1'b0;
        end
      end else if (ov_r && !out_tready) begin
        hold_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      od_r     <= od_nxt;
      ou_r     <= ou_nxt;
      hold_d_r <= od_r;
      hold_u_r <= ou_r;
    end
  end

  assign out_tvalid = hold_v_r | ov_r;
  assign out_tdata  = hold_v_r ? hold_d_r : od_r;
  assign out_tuser  = hold_v_r ? hold_u_r : ou_r;

endmodule

### sim/tb_vec3_vector_alu.sv
// ----------------------------------------------------------------------------
// tb_vec3_vector_alu: self-checking bench for the Q16.16 vector unit
// Drives requests over the in_ stream, predicts every result in the bench
// and compares the out_ stream field by field, in order, under idle phases,
// a long receiver hold-off and a full drain.
// ----------------------------------------------------------------------------
module tb_vec3_vector_alu;
  import vva_pkg::*;

  localparam int WDOG_LIMIT = 4000;
  localparam int HOLD_LEN   = 400;
  localparam int TAIL       = 150;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [31:0] rx, ry, rz, sc;
    logic        sat, dz;
  } vres_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_tvalid = 1'b0;
  logic           in_tready;
  logic [223:0]   in_tdata = '0;   // ax, ay, az, bx, by, bz, scalar_in
  logic [2:0]     in_tuser = '0;   // cmd
  logic           out_tvalid;
  logic           out_tready = 1'b0;
  logic [127:0]   out_tdata;       // rx, ry, rz, scalar_out
  logic [1:0]     out_tuser;       // saturated, div_zero

  vres_t vres_q[$];
  int    err_cnt = 0;
  int    req_cnt = 0;
  int    res_cnt = 0;
  int    snd_idle = 0;
  int    rcv_stall = 0;
  int    hold_req = 0;
  int    hold_seen = 0;
  int    hold_left = 0;
  int    idle_cycles = 0;

  always #6 clk = ~clk;

  vec3_vector_alu dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  function automatic logic [31:0] clampw(input wide_t v, inout logic sat);
    if (v > wide_t'(32'sh7fffffff)) begin
      sat = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -wide_t'(64'sh80000000)) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] round_prod(input wide_t v, inout logic sat);
    return clampw((v + wide_t'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS, sat);
  endfunction

  function automatic logic [31:0] div_rnd(input wide_t num, input wide_t den,
                                          input logic neg_den, inout logic sat);
    wide_t m, q;
    logic  neg;
    neg = (num < 0) != neg_den;
    m = (num < 0) ? -num : num;
    q = (2 * m + den) / (2 * den);
    return clampw(neg ? -q : q, sat);
  endfunction

  function automatic longint unsigned root_rnd(input longint unsigned n);
    longint unsigned res, bitv, rem;
    res = 0;
    bitv = 64'h1 << 62;
    rem = n;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    if (rem > res) res++;
    return res;
  endfunction

  function automatic vres_t alu_predict(input cmd_t cmd, input logic [31:0] a[3],
                                        input logic [31:0] b[3], input logic [31:0] s);
    vres_t r;
    wide_t wa[3], wb[3], ws, den;
    longint unsigned sq, nr;
    logic sat;
    r = '{default: '0};
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      wa[i] = $signed(a[i]);
      wb[i] = $signed(b[i]);
    end
    ws = $signed(s);
    case (cmd)
      CMD_ADD: begin
        r.rx = clampw(wa[0] + wb[0], sat);
        r.ry = clampw(wa[1] + wb[1], sat);
        r.rz = clampw(wa[2] + wb[2], sat);
      end
      CMD_SUB: begin
        r.rx = clampw(wa[0] - wb[0], sat);
        r.ry = clampw(wa[1] - wb[1], sat);
        r.rz = clampw(wa[2] - wb[2], sat);
      end
      CMD_SCALE: begin
        r.rx = round_prod(wa[0] * ws, sat);
        r.ry = round_prod(wa[1] * ws, sat);
        r.rz = round_prod(wa[2] * ws, sat);
      end
      CMD_DIV: begin
        if (ws == 0) begin
          r.dz = 1'b1;
        end else begin
          den = (ws < 0) ? -ws : ws;
          r.rx = div_rnd(wa[0] <<< FRAC_BITS, den, ws < 0, sat);
          r.ry = div_rnd(wa[1] <<< FRAC_BITS, den, ws < 0, sat);
          r.rz = div_rnd(wa[2] <<< FRAC_BITS, den, ws < 0, sat);
        end
      end
      CMD_DOT: begin
        r.sc = round_prod(wa[0] * wb[0] + wa[1] * wb[1] + wa[2] * wb[2], sat);
      end
      CMD_CROSS: begin
        r.rx = round_prod(wa[1] * wb[2] - wa[2] * wb[1], sat);
        r.ry = round_prod(wa[2] * wb[0] - wa[0] * wb[2], sat);
        r.rz = round_prod(wa[0] * wb[1] - wa[1] * wb[0], sat);
      end
      default: begin
        sq = 0;
        for (int i = 0; i < 3; i++) sq = sq + 64'(wa[i] * wa[i]);
        nr = root_rnd(sq);
        if (cmd == CMD_NORM) begin
          r.sc = clampw(wide_t'(nr), sat);
        end else if (nr == 0) begin
          r.dz = 1'b1;
        end else begin
          den = wide_t'(nr);
          r.rx = div_rnd(wa[0] <<< FRAC_BITS, den, 1'b0, sat);
          r.ry = div_rnd(wa[1] <<< FRAC_BITS, den, 1'b0, sat);
          r.rz = div_rnd(wa[2] <<< FRAC_BITS, den, 1'b0, sat);
        end
      end
    endcase
    if (r.dz) begin
      r = '{default: '0};
      r.dz = 1'b1;
      sat = 1'b0;
    end
    r.sat = sat;
    return r;
  endfunction

  task automatic send_req(input cmd_t cmd, input logic [31:0] a[3],
                          input logic [31:0] b[3], input logic [31:0] s);
    if ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < snd_idle) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {s, b[2], b[1], b[0], a[2], a[1], a[0]};
    do @(posedge clk); while (!in_tready);
    vres_q.push_back(alu_predict(cmd, a, b, s));
    req_cnt++;
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("result %0d: %s got %h want %h", res_cnt, field, got, want);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    vres_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (vres_q.size() == 0) begin
        $display("result %0d: no request outstanding", res_cnt);
        err_cnt++;
      end else begin
        e = vres_q.pop_front();
        if (out_tdata[31:0] !== e.rx) report_mismatch("rx", out_tdata[31:0], e.rx);
        if (out_tdata[63:32] !== e.ry) report_mismatch("ry", out_tdata[63:32], e.ry);
        if (out_tdata[95:64] !== e.rz) report_mismatch("rz", out_tdata[95:64], e.rz);
        if (out_tdata[127:96] !== e.sc)
          report_mismatch("scalar_out", out_tdata[127:96], e.sc);
        if (out_tuser[0] !== e.sat)
          report_mismatch("saturated", 32'(out_tuser[0]), 32'(e.sat));
        if (out_tuser[1] !== e.dz)
          report_mismatch("div_zero", 32'(out_tuser[1]), 32'(e.dz));
      end
      res_cnt++;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_LEN;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_stall);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("timeout with %0d results outstanding", vres_q.size());
        $display("tb_vec3_vector_alu: errors");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      2: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      4: return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
      default: return $urandom_range(3) == 0 ? 32'h0 : $urandom;
    endcase
  endfunction

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (vres_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [31:0] a[3], b[3], z[3], mx[3], mn[3];
    z  = '{32'h0, 32'h0, 32'h0};
    mx = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
    mn = '{32'h80000000, 32'h80000000, 32'h80000000};
    a  = '{32'h00010000, 32'hfffe8000, 32'h00030000};
    b  = '{32'h00020000, 32'h00008000, 32'hffff0000};
    for (int c = 0; c < 8; c++) send_req(cmd_t'(c), a, b, 32'h00018000);
    send_req(CMD_ADD, mx, mx, 32'h0);
    send_req(CMD_SUB, mn, mx, 32'h0);
    send_req(CMD_SCALE, mx, z, 32'h80000000);
    send_req(CMD_SCALE, '{32'h1, 32'hffffffff, 32'h8000}, z, 32'h00008000);
    send_req(CMD_DIV, a, b, 32'h0);
    send_req(CMD_DIV, mn, z, 32'h1);
    send_req(CMD_DIV, '{32'h3, 32'hfffffffd, 32'h5}, z, 32'hfffe0000);
    send_req(CMD_DIV, mx, z, 32'h80000000);
    send_req(CMD_DOT, mn, mn, 32'h0);
    send_req(CMD_DOT, mx, mn, 32'h0);
    send_req(CMD_CROSS, mx, mn, 32'h0);
    send_req(CMD_NORM, mn, z, 32'h0);
    send_req(CMD_NORM, z, z, 32'h0);
    send_req(CMD_NRMZ, z, b, 32'h0);
    send_req(CMD_NRMZ, '{32'h1, 32'h0, 32'h0}, z, 32'h0);
    send_req(CMD_NRMZ, mn, z, 32'h0);
    send_req(CMD_NRMZ, mx, mx, 32'hffffffff);
    wait_drain();
  endtask

  task automatic test_random(input int n, input int idle, input int stall);
    logic [31:0] a[3], b[3], s;
    cmd_t cmd;
    snd_idle = idle;
    rcv_stall = stall;
    repeat (n) begin
      cmd = cmd_t'($urandom_range(7));
      for (int i = 0; i < 3; i++) begin
        a[i] = rand_word();
        b[i] = rand_word();
      end
      s = ($urandom_range(9) == 0) ? 32'h0 : rand_word();
      if (cmd == CMD_NRMZ && $urandom_range(9) == 0) a = '{32'h0, 32'h0, 32'h0};
      send_req(cmd, a, b, s);
    end
  endtask

  task automatic test_backpressure();
    hold_req++;
    test_random(100, 0, 0);
    wait_drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(60, 0, 0);
    test_random(60, 69, 0);
    test_random(60, 0, 69);
    test_random(60, 21, 21);
    test_backpressure();
    test_random(30, 21, 21);
    wait_drain();
    repeat (TAIL) @(posedge clk);
    $display("sent %0d requests over all eight opcodes, checked %0d results", req_cnt,
             res_cnt);
    $display("phases: no idling, sender idle, receiver stall, both, long hold-off, drain");
    if (err_cnt == 0 && vres_q.size() == 0) begin
      $display("tb_vec3_vector_alu: clean");
    end else begin
      $display("tb_vec3_vector_alu: errors");
    end
    $finish;
  end

endmodule
